/* design/srtn_pkg.sv */
// Package for the SRTN quantum scheduler: FSM state type and fixed field widths.
// No dependencies.
`default_nettype none
package srtn_pkg;
    localparam int ID_W = 8;
    localparam int FLD_W = 16;
    localparam int SLOT_FLD_W = 4;

    localparam logic FUNC_ARRIVE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_ARR    = 8'b0000_0010,
        ST_SCAN   = 8'b0000_0100,
        ST_SWAIT  = 8'b0000_1000,
        ST_RUNRD  = 8'b0001_0000,
        ST_RUNWT  = 8'b0010_0000,
        ST_RUNEX  = 8'b0100_0000,
        ST_OUT    = 8'b1000_0000
    } state_t;
endpackage
`default_nettype wire

/* design/srtn_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module srtn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* design/srtn_quantum_scheduler_core.sv */
// SRTN scheduler with time quantum: top level, sequencer and task table.
// Depends on srtn_pkg and srtn_ram.
//
// Usage: an input beat (func, task_id, arrival_time, service_time, deadline)
// is taken when in_valid is high and in_stall is low; one result beat per
// input leaves on out_valid/out_stall. The quantum register is written on
// the cfg channel (cfg_valid and cfg_ready); the user must write it only
// while idle, and the block itself does not enforce this. Arrival: the
// item passes ST_ARR (free-slot search on the valid flags), then ST_OUT,
// which loads the output register. Tick: a reselection scans the table
// through the remaining-time RAM slot by slot (address in ST_SCAN, then
// compare in ST_SWAIT); the run states ST_RUNRD, ST_RUNWT and ST_RUNEX
// follow when a task is found; without reselection the tick goes straight
// to them. One item is in work at a time; a new input is taken once the
// previous result beat sits in the output register, and is held off while
// a result waits on out_stall.
// Reset clears the valid flags, running slot, counters and sets the quantum
// to 3; the RAM contents need no clearing.
`default_nettype none
module srtn_quantum_scheduler_core
    import srtn_pkg::*;
#(
    parameter int SLOTS = 16,
    parameter int TIME_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        func,
    input  wire logic [7:0]  task_id,
    input  wire logic [15:0] arrival_time,
    input  wire logic [15:0] service_time,
    input  wire logic [15:0] deadline,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  quantum,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             kind,
    output logic             accepted,
    output logic [3:0]       slot,
    output logic             busy_res,
    output logic [7:0]       running_id,
    output logic             finished,
    output logic [15:0]      wait_ticks,
    output logic [15:0]      turnaround_ticks,
    output logic             deadline_met
);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int EW = ID_W + 4 * TIME_BITS;
    localparam logic [TIME_BITS-1:0] TMAX = '1;

    // entry word: {id, arrival, service, deadline, first_run}; remaining separate
    logic          ent_we;
    logic [SW-1:0] ent_waddr, ent_raddr;
    logic [EW-1:0] ent_wdata, ent_rdata;
    logic          rem_we;
    logic [SW-1:0] rem_waddr, rem_raddr;
    logic [TIME_BITS-1:0] rem_wdata, rem_rdata;

    srtn_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_ent (
        .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
        .raddr(ent_raddr), .rdata(ent_rdata)
    );
    srtn_ram #(.WIDTH(TIME_BITS), .DEPTH(SLOTS)) u_rem (
        .clk(clk), .we(rem_we), .waddr(rem_waddr), .wdata(rem_wdata),
        .raddr(rem_raddr), .rdata(rem_rdata)
    );

    state_t state_reg, state_next;
    logic [SLOTS-1:0] valid_reg, valid_next;
    logic [SW-1:0] run_reg, run_next;
    logic [7:0] qcnt_reg, qcnt_next;
    logic [7:0] quant_reg, quant_next;
    logic [TIME_BITS-1:0] time_reg, time_next;
    logic [SW:0] idx_reg, idx_next;
    logic [SW-1:0] cand_reg, cand_next;
    logic [SW-1:0] best_reg, best_next;
    logic [TIME_BITS-1:0] bestrem_reg, bestrem_next;
    logic found_reg, found_next;
    logic [ID_W-1:0] id_reg;
    logic [FLD_W-1:0] arr_reg, svc_reg, dl_reg;
    logic ov_reg, ov_next;
    logic kind_reg, kind_next, acc_reg, acc_next, busy_reg, busy_next;
    logic fin_reg, fin_next, dm_reg, dm_next;
    logic [3:0] slot_reg, slot_next;
    logic [7:0] rid_reg, rid_next;
    logic [15:0] wt_reg, wt_next, ta_reg, ta_next;

    // free slot search
    logic          free_any;
    logic [SW-1:0] free_idx;
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = SW'(i);
            end
        end
    end

    // fields of the entry read
    logic [ID_W-1:0]      e_id;
    logic [TIME_BITS-1:0] e_arr, e_svc, e_dl, e_fr;
    assign {e_id, e_arr, e_svc, e_dl, e_fr} = ent_rdata;

    logic need_sel, qhit;
    logic [7:0] qbase;
    assign qhit = (qcnt_reg >= quant_reg);
    assign qbase = qhit ? 8'd0 : qcnt_reg;
    assign need_sel = (qbase == 8'd0) || !valid_reg[run_reg];

    logic [TIME_BITS-1:0] t_inc, first_run, rem_dec, ta_full, wt_full;
    logic done;
    assign t_inc = (time_reg != TMAX) ? time_reg + 1'b1 : time_reg;
    assign first_run = (rem_rdata == e_svc) ? time_reg : e_fr;
    assign rem_dec = (rem_rdata != '0) ? rem_rdata - 1'b1 : rem_rdata;
    assign done = (rem_dec == '0);
    assign ta_full = (t_inc > e_arr) ? t_inc - e_arr : '0;
    assign wt_full = (first_run > e_arr) ? first_run - e_arr : '0;

    function automatic logic [15:0] clamp16(input logic [TIME_BITS-1:0] v);
        logic [TIME_BITS+15:0] w;
        w = {16'd0, v};
        return (w > (TIME_BITS+16)'(16'hFFFF)) ? 16'hFFFF : w[15:0];
    endfunction

    assign in_stall = !(state_reg == ST_IDLE) || (ov_reg && out_stall);
    assign cfg_ready = 1'b1;
    logic in_acc;
    assign in_acc = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        valid_next = valid_reg;
        run_next = run_reg;
        qcnt_next = qcnt_reg;
        quant_next = (cfg_valid) ? quantum : quant_reg;
        time_next = time_reg;
        idx_next = idx_reg;
        cand_next = cand_reg;
        best_next = best_reg;
        bestrem_next = bestrem_reg;
        found_next = found_reg;
        ov_next = ov_reg && out_stall;
        kind_next = kind_reg; acc_next = acc_reg; busy_next = busy_reg;
        fin_next = fin_reg; dm_next = dm_reg; slot_next = slot_reg;
        rid_next = rid_reg; wt_next = wt_reg; ta_next = ta_reg;
        ent_we = 1'b0; ent_waddr = run_reg; ent_raddr = run_reg;
        ent_wdata = {e_id, e_arr, e_svc, e_dl, first_run};
        rem_we = 1'b0; rem_waddr = run_reg; rem_raddr = run_reg;
        rem_wdata = rem_dec;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = (func == FUNC_TICK) ? ST_SCAN : ST_ARR;
                    idx_next = '0;
                    found_next = 1'b0;
                end
            end
            ST_ARR:
            begin
                ent_we = free_any;
                ent_waddr = free_idx;
                ent_wdata = {id_reg, TIME_BITS'(arr_reg), TIME_BITS'(svc_reg),
                             TIME_BITS'(dl_reg), {TIME_BITS{1'b0}}};
                rem_we = free_any;
                rem_waddr = free_idx;
                rem_wdata = TIME_BITS'(svc_reg);
                if (free_any)
                begin
                    valid_next[free_idx] = 1'b1;
                end
                kind_next = 1'b0; acc_next = free_any;
                slot_next = free_any ? 4'(free_idx) : 4'd0;
                busy_next = 1'b0; rid_next = '0; fin_next = 1'b0;
                wt_next = '0; ta_next = '0; dm_next = 1'b0;
                state_next = ST_OUT;
            end
            ST_SCAN:
            begin
                if (!need_sel)
                begin
                    qcnt_next = qbase;
                    state_next = ST_RUNRD;
                end
                else if (idx_reg == (SW+1)'(SLOTS))
                begin
                    state_next = ST_SWAIT;
                end
                else
                begin
                    rem_raddr = idx_reg[SW-1:0];
                    cand_next = idx_reg[SW-1:0];
                    idx_next = idx_reg + 1'b1;
                    state_next = ST_SWAIT;
                end
            end
            ST_SWAIT:
            begin
                // compare the previous read, then continue or finish
                if (idx_reg != '0 && valid_reg[cand_reg] &&
                    (!found_reg || rem_rdata < bestrem_reg) &&
                    !(idx_reg == (SW+1)'(SLOTS) && cand_reg != SW'(SLOTS - 1)))
                begin
                    best_next = cand_reg;
                    bestrem_next = rem_rdata;
                    found_next = 1'b1;
                end
                if (idx_reg == (SW+1)'(SLOTS) && cand_reg != SW'(SLOTS - 1))
                begin
                    cand_next = SW'(SLOTS - 1);
                end
                state_next = ST_SCAN;
                if (idx_reg == (SW+1)'(SLOTS) && cand_reg == SW'(SLOTS - 1))
                begin
                    cand_next = '0;
                    if (!found_next)
                    begin
                        time_next = t_inc;
                        qcnt_next = '0;
                        kind_next = 1'b1; acc_next = 1'b0; slot_next = '0;
                        busy_next = 1'b0; rid_next = '0; fin_next = 1'b0;
                        wt_next = '0; ta_next = '0; dm_next = 1'b0;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        run_next = best_next;
                        qcnt_next = qbase;
                        state_next = ST_RUNRD;
                    end
                end
            end
            ST_RUNRD:
            begin
                state_next = ST_RUNWT;
            end
            ST_RUNWT:
            begin
                state_next = ST_RUNEX;
            end
            ST_RUNEX:
            begin
                ent_we = (rem_rdata == e_svc);
                rem_we = 1'b1;
                time_next = t_inc;
                kind_next = 1'b1; acc_next = 1'b0; slot_next = 4'(run_reg);
                busy_next = 1'b1; rid_next = e_id; fin_next = done;
                wt_next = done ? clamp16(wt_full) : '0;
                ta_next = done ? clamp16(ta_full) : '0;
                dm_next = done && (ta_full <= e_dl);
                if (done)
                begin
                    valid_next[run_reg] = 1'b0;
                    qcnt_next = '0;
                end
                else
                begin
                    qcnt_next = (qcnt_reg != 8'hFF) ? qcnt_reg + 1'b1 : qcnt_reg;
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            run_reg <= '0;
            qcnt_reg <= '0;
            quant_reg <= 8'd3;
            time_reg <= '0;
            idx_reg <= '0;
            found_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            run_reg <= run_next;
            qcnt_reg <= qcnt_next;
            quant_reg <= quant_next;
            time_reg <= time_next;
            idx_reg <= idx_next;
            found_reg <= found_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg <= cand_next;
        best_reg <= best_next;
        bestrem_reg <= bestrem_next;
        kind_reg <= kind_next; acc_reg <= acc_next; busy_reg <= busy_next;
        fin_reg <= fin_next; dm_reg <= dm_next; slot_reg <= slot_next;
        rid_reg <= rid_next; wt_reg <= wt_next; ta_reg <= ta_next;
        if (in_acc)
        begin
            id_reg <= task_id;
            arr_reg <= arrival_time;
            svc_reg <= service_time;
            dl_reg <= deadline;
        end
    end

    assign out_valid = ov_reg;
    assign kind = kind_reg;
    assign accepted = acc_reg;
    assign slot = slot_reg;
    assign busy_res = busy_reg;
    assign running_id = rid_reg;
    assign finished = fin_reg;
    assign wait_ticks = wt_reg;
    assign turnaround_ticks = ta_reg;
    assign deadline_met = dm_reg;

    a_fin_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && finished |-> busy_res && kind)
        else $error("finished without a running task");
    a_one_state: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state not one-hot");
    a_idle_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> state_reg != ST_IDLE)
        else $error("item accepted without leaving idle");
endmodule
`default_nettype wire
